### src/lfpd_pkg.sv
// shared types, register map, reset values and the line position table
package lfpd_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_KP_GAIN         = 3'd0;
    localparam logic [2:0] REG_KD_GAIN         = 3'd1;
    localparam logic [2:0] REG_BASE_SPEED      = 3'd2;
    localparam logic [2:0] REG_LINE_SETPOINT   = 3'd3;
    localparam logic [2:0] REG_DUTY_SCALE      = 3'd4;
    localparam logic [2:0] REG_TURN_FAST_SPEED = 3'd5;
    localparam logic [2:0] REG_TURN_SLOW_SPEED = 3'd6;

    // register reset values
    localparam logic [15:0] RST_KP_GAIN         = 16'd393;
    localparam logic [15:0] RST_KD_GAIN         = 16'd1966;
    localparam logic [11:0] RST_BASE_SPEED      = 12'd40;
    localparam logic [12:0] RST_LINE_SETPOINT   = 13'd3000;
    localparam logic [7:0]  RST_DUTY_SCALE      = 8'd10;
    localparam logic [11:0] RST_TURN_FAST_SPEED = 12'd40;
    localparam logic [11:0] RST_TURN_SLOW_SPEED = 12'hFF6;

    // remembered side codes
    localparam logic [1:0] SIDE_NONE   = 2'd0;
    localparam logic [1:0] SIDE_LEFT   = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_CENTRE = 2'd3;

    localparam logic [15:0] DUTY_MAX = 16'hFFFF;

    // configuration register set
    typedef struct packed {
        logic [15:0]        kp_gain;
        logic [15:0]        kd_gain;
        logic signed [11:0] base_speed;
        logic [12:0]        line_setpoint;
        logic [7:0]         duty_scale;
        logic signed [11:0] turn_fast_speed;
        logic signed [11:0] turn_slow_speed;
    } t_cfg;

    // classified sensor sample passed from front to back
    typedef struct packed {
        logic        lost;
        logic        lamp;
        logic [1:0]  side;
        logic [12:0] position;
    } t_cmd;

    // weighted line position divided by the active sensor count
    function automatic logic [12:0] line_position(input logic [4:0] bits);
        logic [12:0] pos;
        begin
            unique case (bits)
                5'd1:    pos = 13'd1200;
                5'd2:    pos = 13'd2400;
                5'd3:    pos = 13'd1800;
                5'd4:    pos = 13'd3000;
                5'd5:    pos = 13'd2100;
                5'd6:    pos = 13'd2700;
                5'd7:    pos = 13'd2200;
                5'd8:    pos = 13'd3600;
                5'd9:    pos = 13'd2400;
                5'd10:   pos = 13'd3000;
                5'd11:   pos = 13'd2400;
                5'd12:   pos = 13'd3300;
                5'd13:   pos = 13'd2600;
                5'd14:   pos = 13'd3000;
                5'd15:   pos = 13'd2550;
                5'd16:   pos = 13'd4800;
                5'd17:   pos = 13'd3000;
                5'd18:   pos = 13'd3600;
                5'd19:   pos = 13'd2800;
                5'd20:   pos = 13'd3900;
                5'd21:   pos = 13'd3000;
                5'd22:   pos = 13'd3400;
                5'd23:   pos = 13'd2850;
                5'd24:   pos = 13'd4200;
                5'd25:   pos = 13'd3200;
                5'd26:   pos = 13'd3600;
                5'd27:   pos = 13'd3000;
                5'd28:   pos = 13'd3800;
                5'd29:   pos = 13'd3150;
                5'd30:   pos = 13'd3450;
                5'd31:   pos = 13'd3000;
                default: pos = 13'd0;
            endcase
            return pos;
        end
    endfunction

endpackage

### src/lfpd_front.sv
// front end: takes sensor samples, tracks the remembered side, looks up position
module lfpd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [4:0]           i_center_sensors,
    input  logic                 i_left_edge,
    input  logic                 i_right_edge,
    input  logic                 i_queue_full,
    output logic                 o_queue_wr,
    output lfpd_pkg::t_cmd       o_queue_data
);
    import lfpd_pkg::*;

    logic [1:0] r_side;
    logic [1:0] n_side;
    logic       accept;

    assign full   = i_queue_full;
    assign accept = push && !i_queue_full;

    // side memory update for this sample
    always_comb begin
        n_side = r_side;
        if ((i_center_sensors & 5'b01110) != 5'd0) begin
            n_side = SIDE_CENTRE;
        end
        if (i_left_edge) begin
            n_side = SIDE_LEFT;
        end else if (i_right_edge) begin
            n_side = SIDE_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_NONE;
        end else if (accept) begin
            r_side <= n_side;
        end
    end

    // classified sample into the queue
    assign o_queue_wr            = accept;
    assign o_queue_data.lost     = (i_center_sensors == 5'd0);
    assign o_queue_data.lamp     = i_center_sensors[2];
    assign o_queue_data.side     = n_side;
    assign o_queue_data.position = line_position(i_center_sensors);

endmodule

### src/lfpd_queue.sv
// short queue of classified samples between front and back
module lfpd_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  lfpd_pkg::t_cmd i_wr_data,
    output logic           o_full,
    input  logic           i_rd,
    output lfpd_pkg::t_cmd o_rd_data,
    output logic           o_empty
);
    import lfpd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/lfpd_back.sv
// back end: pd sequencer on one shared multiplier, duty drive and result register
module lfpd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lfpd_pkg::t_cfg       i_cfg,
    input  logic                 i_queue_empty,
    input  lfpd_pkg::t_cmd       i_queue_data,
    output logic                 o_queue_rd,
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          o_left_forward_duty,
    output logic [15:0]          o_left_reverse_duty,
    output logic [15:0]          o_right_forward_duty,
    output logic [15:0]          o_right_reverse_duty,
    output logic                 o_center_lamp,
    output logic                 o_line_lost,
    output logic signed [13:0]   o_track_error
);
    import lfpd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_MULP = 4'd2;
    localparam logic [3:0] S_MULD = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_CORR = 4'd5;
    localparam logic [3:0] S_SPD  = 4'd6;
    localparam logic [3:0] S_DRVL = 4'd7;
    localparam logic [3:0] S_DRVR = 4'd8;
    localparam logic [3:0] S_SATR = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]          r_state;
    t_cmd                r_cmd;
    logic signed [13:0]  r_prev_err;
    logic signed [13:0]  r_err;
    logic signed [14:0]  r_deriv;
    logic signed [33:0]  r_prod;
    logic signed [34:0]  r_acc;
    logic signed [16:0]  r_corr;
    logic signed [16:0]  r_spd_l;
    logic signed [16:0]  r_spd_r;
    logic [15:0]         r_duty [4];
    logic                r_out_valid;
    logic [15:0]         r_out_duty [4];
    logic                r_out_lamp;
    logic                r_out_lost;
    logic signed [13:0]  r_out_err;

    logic signed [16:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic signed [33:0]  mul_p;
    logic signed [16:0]  abs_l;
    logic signed [16:0]  abs_r;
    logic signed [34:0]  acc_biased;
    logic signed [13:0]  err_now;
    logic signed [16:0]  base_ext;
    logic signed [16:0]  fast_ext;
    logic signed [16:0]  slow_ext;
    logic [15:0]         sat_duty;
    logic                out_free;

    assign base_ext = 17'(i_cfg.base_speed);
    assign fast_ext = 17'(i_cfg.turn_fast_speed);
    assign slow_ext = 17'(i_cfg.turn_slow_speed);
    assign abs_l    = r_spd_l[16] ? -r_spd_l : r_spd_l;
    assign abs_r    = r_spd_r[16] ? -r_spd_r : r_spd_r;
    assign err_now  = $signed({1'b0, i_cfg.line_setpoint}) - $signed({1'b0, r_cmd.position});
    assign out_free = !r_out_valid || pop;

    // truncation toward zero before the 16 bit shift
    assign acc_biased = r_acc + (r_acc[34] ? 35'sd65535 : 35'sd0);

    // saturated magnitude from the last product
    assign sat_duty = (r_prod > 34'sd65535) ? DUTY_MAX : r_prod[15:0];

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MULP: begin
                mul_a = 17'(r_err);
                mul_b = $signed({1'b0, i_cfg.kp_gain});
            end
            S_MULD: begin
                mul_a = 17'(r_deriv);
                mul_b = $signed({1'b0, i_cfg.kd_gain});
            end
            S_DRVL: begin
                mul_a = $signed({1'b0, abs_l[15:0]});
                mul_b = $signed({9'd0, i_cfg.duty_scale});
            end
            S_DRVR: begin
                mul_a = $signed({1'b0, abs_r[15:0]});
                mul_b = $signed({9'd0, i_cfg.duty_scale});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign o_queue_rd = (r_state == S_IDLE) && !i_queue_empty;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_err <= '0;
            for (int i = 0; i < 4; i++) begin
                r_duty[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_queue_empty) begin
                        r_cmd <= i_queue_data;
                        if (!i_queue_data.lost) begin
                            r_state <= S_ERR;
                        end else begin
                            unique case (i_queue_data.side)
                                SIDE_LEFT: begin
                                    r_spd_l <= slow_ext;
                                    r_spd_r <= fast_ext;
                                    r_state <= S_DRVL;
                                end
                                SIDE_RIGHT: begin
                                    r_spd_l <= fast_ext;
                                    r_spd_r <= slow_ext;
                                    r_state <= S_DRVL;
                                end
                                SIDE_CENTRE: begin
                                    r_spd_l <= fast_ext;
                                    r_spd_r <= fast_ext;
                                    r_state <= S_DRVL;
                                end
                                default: begin
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_ERR: begin
                    r_err      <= err_now;
                    r_deriv    <= 15'(err_now) - 15'(r_prev_err);
                    r_prev_err <= err_now;
                    r_state    <= S_MULP;
                end
                S_MULP: begin
                    r_prod  <= mul_p;
                    r_state <= S_MULD;
                end
                S_MULD: begin
                    r_acc   <= 35'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + 35'(r_prod);
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    r_corr  <= acc_biased[32:16];
                    r_state <= S_SPD;
                end
                S_SPD: begin
                    r_spd_l <= base_ext - r_corr;
                    r_spd_r <= base_ext + r_corr;
                    r_state <= S_DRVL;
                end
                S_DRVL: begin
                    r_prod  <= mul_p;
                    r_state <= S_DRVR;
                end
                S_DRVR: begin
                    r_duty[0] <= (r_spd_l > 17'sd0) ? sat_duty : 16'd0;
                    r_duty[1] <= (r_spd_l < 17'sd0) ? sat_duty : 16'd0;
                    r_prod    <= mul_p;
                    r_state   <= S_SATR;
                end
                S_SATR: begin
                    r_duty[2] <= (r_spd_r > 17'sd0) ? sat_duty : 16'd0;
                    r_duty[3] <= (r_spd_r < 17'sd0) ? sat_duty : 16'd0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            for (int i = 0; i < 4; i++) begin
                r_out_duty[i] <= r_duty[i];
            end
            r_out_lamp <= r_cmd.lamp;
            r_out_lost <= r_cmd.lost;
            r_out_err  <= r_prev_err;
        end
    end

    assign empty                = !r_out_valid;
    assign o_left_forward_duty  = r_out_duty[0];
    assign o_left_reverse_duty  = r_out_duty[1];
    assign o_right_forward_duty = r_out_duty[2];
    assign o_right_reverse_duty = r_out_duty[3];
    assign o_center_lamp        = r_out_lamp;
    assign o_line_lost          = r_out_lost;
    assign o_track_error        = r_out_err;

endmodule

### src/line_follower_pd_drive_unit.sv
// PD line-follower motor drive: a sensor sample is pushed in and one set of motor duties
// is popped out for each. The front end files each sample in a QUEUE_DEPTH-entry queue;
// the back end works through it with one shared 17x17 multiplier, one product a cycle.
// From leaving the queue to the result register a sample goes through error, two gain
// products, sum, rounding, speeds, two duty products and saturation when the line is seen,
// the duty products and saturation on a recovery turn, and straight through when the held
// duties are repeated; the back end sequencer sets the sustained rate. A finished result
// waits in its own register while the next sample is worked on. Registers sit on the
// APB-style port at byte addresses 4*index and may be written only while the block is idle.
module line_follower_pd_drive_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // sample side
    input  logic                 push,
    output logic                 full,
    input  logic [4:0]           i_center_sensors,
    input  logic                 i_left_edge,
    input  logic                 i_right_edge,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          o_left_forward_duty,
    output logic [15:0]          o_left_reverse_duty,
    output logic [15:0]          o_right_forward_duty,
    output logic [15:0]          o_right_reverse_duty,
    output logic                 o_center_lamp,
    output logic                 o_line_lost,
    output logic signed [13:0]   o_track_error
);
    import lfpd_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       q_full;
    logic       q_empty;
    logic       q_wr;
    logic       q_rd;
    t_cmd       q_wr_data;
    t_cmd       q_rd_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain         <= RST_KP_GAIN;
            r_cfg.kd_gain         <= RST_KD_GAIN;
            r_cfg.base_speed      <= RST_BASE_SPEED;
            r_cfg.line_setpoint   <= RST_LINE_SETPOINT;
            r_cfg.duty_scale      <= RST_DUTY_SCALE;
            r_cfg.turn_fast_speed <= RST_TURN_FAST_SPEED;
            r_cfg.turn_slow_speed <= RST_TURN_SLOW_SPEED;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KP_GAIN:         r_cfg.kp_gain         <= pwdata[15:0];
                REG_KD_GAIN:         r_cfg.kd_gain         <= pwdata[15:0];
                REG_BASE_SPEED:      r_cfg.base_speed      <= pwdata[11:0];
                REG_LINE_SETPOINT:   r_cfg.line_setpoint   <= pwdata[12:0];
                REG_DUTY_SCALE:      r_cfg.duty_scale      <= pwdata[7:0];
                REG_TURN_FAST_SPEED: r_cfg.turn_fast_speed <= pwdata[11:0];
                REG_TURN_SLOW_SPEED: r_cfg.turn_slow_speed <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_KP_GAIN:         prdata = {16'd0, r_cfg.kp_gain};
            REG_KD_GAIN:         prdata = {16'd0, r_cfg.kd_gain};
            REG_BASE_SPEED:      prdata = {20'd0, r_cfg.base_speed};
            REG_LINE_SETPOINT:   prdata = {19'd0, r_cfg.line_setpoint};
            REG_DUTY_SCALE:      prdata = {24'd0, r_cfg.duty_scale};
            REG_TURN_FAST_SPEED: prdata = {20'd0, r_cfg.turn_fast_speed};
            REG_TURN_SLOW_SPEED: prdata = {20'd0, r_cfg.turn_slow_speed};
            default:             prdata = 32'd0;
        endcase
    end

    // sample intake and classification
    lfpd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_center_sensors (i_center_sensors),
        .i_left_edge      (i_left_edge),
        .i_right_edge     (i_right_edge),
        .i_queue_full     (q_full),
        .o_queue_wr       (q_wr),
        .o_queue_data     (q_wr_data)
    );

    // decoupling queue
    lfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // pd computation and duty drive
    lfpd_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_queue_empty        (q_empty),
        .i_queue_data         (q_rd_data),
        .o_queue_rd           (q_rd),
        .empty                (empty),
        .pop                  (pop),
        .o_left_forward_duty  (o_left_forward_duty),
        .o_left_reverse_duty  (o_left_reverse_duty),
        .o_right_forward_duty (o_right_forward_duty),
        .o_right_reverse_duty (o_right_reverse_duty),
        .o_center_lamp        (o_center_lamp),
        .o_line_lost          (o_line_lost),
        .o_track_error        (o_track_error)
    );

endmodule
